FILE: rtl/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store.
// Used by pls_ctrl, pls_datapath and positional_list_store; no dependencies.
package pls_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_PREPEND   = 3'd1,
        CMD_REM_FIRST = 3'd2,
        CMD_REM_LAST  = 3'd3,
        CMD_REM_AT    = 3'd4,
        CMD_INS_AT    = 3'd5,
        CMD_READ      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OUT,
        S_READ
    } state_t;

    typedef struct packed {
        logic accept;
        logic rotate;
        logic show_elem;
    } ctl_cmd_t;

    typedef struct packed {
        logic read_go;
        logic last_elem;
    } dp_stat_t;

endpackage

FILE: rtl/pls_ctrl.sv
// pls_ctrl: sequencer for the positional list store.
// Depends on pls_pkg; drives pls_datapath through ctl_cmd_t.
module pls_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pls_pkg::dp_stat_t  stat,
    output pls_pkg::ctl_cmd_t  cmd
);

    pls_pkg::state_t state_reg;
    pls_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.read_go ? pls_pkg::S_READ : pls_pkg::S_OUT;
                end
            end
            pls_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            pls_pkg::S_READ:
            begin
                if (out_ready && stat.last_elem)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.accept    = 1'b0;
        cmd.rotate    = 1'b0;
        cmd.show_elem = 1'b0;
        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            pls_pkg::S_OUT:
            begin
                out_valid = 1'b1;
            end
            pls_pkg::S_READ:
            begin
                out_valid     = 1'b1;
                cmd.show_elem = 1'b1;
                cmd.rotate    = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/pls_datapath.sv
// pls_datapath: shifting entry cells, count, command decode and result fields.
// Depends on pls_pkg; controlled by pls_ctrl.
module pls_datapath #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int PW       = $clog2(CAPACITY + 2)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pls_pkg::ctl_cmd_t                 cmd,
    output pls_pkg::dp_stat_t                 stat,
    input  logic [2:0]                        command,
    input  logic [PW-1:0]                     position,
    input  logic signed [pls_pkg::DATA_W-1:0] data_value,
    output logic signed [pls_pkg::DATA_W-1:0] element_value,
    output logic [CW-1:0]                     entry_count,
    output logic [1:0]                        status,
    output logic                              last_of_run
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [pls_pkg::DATA_W-1:0] entry_reg  [CAPACITY];
    logic signed [pls_pkg::DATA_W-1:0] entry_next [CAPACITY];
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     left_reg, left_next;
    pls_pkg::status_t                  status_reg, status_next;

    pls_pkg::op_t     op;
    pls_pkg::status_t st;
    logic [PW-1:0]    slot_w;
    logic [IW-1:0]    slot;
    logic [PW-1:0]    cnt_x;
    logic             full;
    logic             empty;
    logic [CW-1:0]    last_idx;

    assign cnt_x    = PW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign slot     = slot_w[IW-1:0];
    assign last_idx = count_reg - CW'(1);

    always_comb
    begin
        op     = pls_pkg::OP_HOLD;
        st     = pls_pkg::ST_DONE;
        slot_w = '0;
        unique case (pls_pkg::cmd_t'(command))
            pls_pkg::CMD_APPEND:
            begin
                if (full) st = pls_pkg::ST_FULL;
                else
                begin
                    op     = pls_pkg::OP_INSERT;
                    slot_w = cnt_x;
                end
            end
            pls_pkg::CMD_PREPEND:
            begin
                if (full) st = pls_pkg::ST_FULL;
                else op = pls_pkg::OP_INSERT;
            end
            pls_pkg::CMD_REM_FIRST:
            begin
                if (empty) st = pls_pkg::ST_IGNORED;
                else op = pls_pkg::OP_REMOVE;
            end
            pls_pkg::CMD_REM_LAST:
            begin
                if (empty) st = pls_pkg::ST_IGNORED;
                else
                begin
                    op     = pls_pkg::OP_REMOVE;
                    slot_w = cnt_x - PW'(1);
                end
            end
            pls_pkg::CMD_REM_AT:
            begin
                if (position == '0 || position > cnt_x) st = pls_pkg::ST_IGNORED;
                else
                begin
                    op     = pls_pkg::OP_REMOVE;
                    slot_w = position - PW'(1);
                end
            end
            pls_pkg::CMD_INS_AT:
            begin
                if (position == '0 || position > cnt_x + PW'(1)) st = pls_pkg::ST_IGNORED;
                else if (full) st = pls_pkg::ST_FULL;
                else
                begin
                    op     = pls_pkg::OP_INSERT;
                    slot_w = position - PW'(1);
                end
            end
            pls_pkg::CMD_READ:
            begin
                st = empty ? pls_pkg::ST_EMPTY : pls_pkg::ST_DONE;
            end
            default:
            begin
                st = pls_pkg::ST_IGNORED;
            end
        endcase
    end

    assign stat.read_go   = (pls_pkg::cmd_t'(command) == pls_pkg::CMD_READ) && !empty;
    assign stat.last_elem = (left_reg == CW'(1));

    // cells see neighbors or cell 0; rotate cycles the occupied span for read out
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.accept && op == pls_pkg::OP_INSERT)
            begin
                if (IW'(i) == slot) entry_next[i] = data_value;
                else if (IW'(i) > slot)
                begin
                    if (i > 0) entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.accept && op == pls_pkg::OP_REMOVE)
            begin
                if (IW'(i) >= slot && i < CAPACITY - 1)
                begin
                    entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
            else if (cmd.rotate)
            begin
                if (CW'(i) == last_idx) entry_next[i] = entry_reg[0];
                else if (CW'(i) < last_idx && i < CAPACITY - 1)
                begin
                    entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        left_next   = left_reg;
        status_next = status_reg;
        if (cmd.accept)
        begin
            status_next = st;
            left_next   = count_reg;
            if (op == pls_pkg::OP_INSERT) count_next = count_reg + CW'(1);
            else if (op == pls_pkg::OP_REMOVE) count_next = count_reg - CW'(1);
        end
        else if (cmd.rotate)
        begin
            left_next = left_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        status_reg <= status_next;
    end

    assign element_value = cmd.show_elem ? entry_reg[0] : '0;
    assign entry_count   = count_reg;
    assign status        = status_reg;
    assign last_of_run   = cmd.show_elem ? stat.last_elem : 1'b1;

endmodule

FILE: rtl/positional_list_store.sv
// positional_list_store: top level, bounded ordered list with positional edits.
// Depends on pls_pkg, pls_ctrl and pls_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_ready  | command, position, data_value
//  output  | out_valid / out_ready| element_value, entry_count, status, last_of_run
//
// One item at a time: every edit of the entry cells is done in the cycle the item
// is accepted, by neighbor shifts; the status result is offered from the next cycle.
// Read out gives one element per cycle, the cells rotating once per element taken.
// Read out stalls while out_ready is low; an empty list gives only the status.
// Reset clears the count and the sequencer state only; entry contents are undefined until written.
// in_ready is low while any result of the current item is pending.
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int PW       = $clog2(CAPACITY + 2)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        command,
    input  logic [PW-1:0]                     position,
    input  logic signed [pls_pkg::DATA_W-1:0] data_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pls_pkg::DATA_W-1:0] element_value,
    output logic [CW-1:0]                     entry_count,
    output logic [1:0]                        status,
    output logic                              last_of_run
);

    pls_pkg::ctl_cmd_t cmd;
    pls_pkg::dp_stat_t stat;

    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pls_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .PW       (PW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .command       (command),
        .position      (position),
        .data_value    (data_value),
        .element_value (element_value),
        .entry_count   (entry_count),
        .status        (status),
        .last_of_run   (last_of_run)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after accepted item");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_run) |=> !out_valid)
        else $error("result offered after final result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CW'(CAPACITY))
        else $error("count above capacity");
`endif

endmodule
